// ===== rtl/ip6p_pkg.sv =====
// ip6p_pkg: shared constants and types for the ipv6 text address parser
// no dependencies; used by the top level and its checker

package ip6p_pkg;

  localparam int GROUPS  = 8;
  localparam int GROUP_W = 16;
  localparam int DIGIT_W = 4;
  localparam int IDX_W   = $clog2(GROUPS);
  localparam int CHAR_W  = 8;
  localparam int ADDR_W  = GROUPS * GROUP_W;
  localparam int HALF_W  = ADDR_W / 2;

  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(GROUPS - 1);

  // character codes
  localparam logic [CHAR_W-1:0] CH_0        = 8'h30;
  localparam logic [CHAR_W-1:0] CH_9        = 8'h39;
  localparam logic [CHAR_W-1:0] CH_COLON    = 8'h3a;
  localparam logic [CHAR_W-1:0] CH_UP_A     = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z     = 8'h5a;
  localparam logic [CHAR_W-1:0] CH_LO_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_F     = 8'h66;
  localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'h20;
  // low nibble of 'a'..'f' is 1..6, so adding this gives 10..15
  localparam logic [DIGIT_W-1:0] ALPHA_ADJ  = 4'd9;

  // parse status codes
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef logic [GROUPS-1:0][GROUP_W-1:0] grp_arr_t;
  typedef logic [IDX_W-1:0]               grp_idx_t;

endpackage

// ===== rtl/ipv6_text_address_parser_top.sv =====
// Takes one character of an ipv6 address text per item and, on the item marked
// tlast, outputs the 128-bit address in the next cycle. An item is taken in every
// cycle while the output register is empty or being drained; the only limit on
// rate is the single output register, so the sustained rate is one character
// per cycle while a result is not held in that register by a stalled receiver.
// Upper case is folded, groups wrap at 16 bits, one '::' gap is right-aligned;
// a bad character, a ninth group or a second gap gives status 1 and a zero address.
// depends on ip6p_pkg

module ipv6_text_address_parser_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] char_in
  input  logic         in_tlast,   // last_char
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [127:0] out_tdata,  // [63:0] addr_high, [127:64] addr_low
  output logic [0:0]   out_tuser   // [0] parse_status
);

  ip6p_pkg::grp_arr_t grp_r, grp_nxt;
  ip6p_pkg::grp_idx_t idx_r, idx_nxt;
  ip6p_pkg::grp_idx_t gap_pos_r, gap_pos_nxt;
  ip6p_pkg::grp_idx_t shift_amt;
  logic prev_colon_r, prev_colon_nxt;
  logic gap_r, gap_nxt;
  logic err_r, err_nxt;

  logic [ip6p_pkg::CHAR_W-1:0]  lc;
  logic                         is_dec, is_alpha;
  logic [ip6p_pkg::DIGIT_W-1:0] digit;

  logic [ip6p_pkg::ADDR_W-1:0]  head, tail, words, addr;
  logic [ip6p_pkg::ADDR_W-1:0]  out_data_r, out_data_nxt;
  logic                         out_status_r, out_status_nxt;
  logic                         out_valid_r;
  logic                         accept;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // character decode and state update
  always_comb begin
    lc = in_tdata;
    if (in_tdata inside {[ip6p_pkg::CH_UP_A:ip6p_pkg::CH_UP_Z]}) begin
      lc = in_tdata + ip6p_pkg::CASE_OFFSET;
    end
    is_dec   = lc inside {[ip6p_pkg::CH_0:ip6p_pkg::CH_9]};
    is_alpha = lc inside {[ip6p_pkg::CH_LO_A:ip6p_pkg::CH_LO_F]};
    digit    = is_dec ? lc[ip6p_pkg::DIGIT_W-1:0]
                      : lc[ip6p_pkg::DIGIT_W-1:0] + ip6p_pkg::ALPHA_ADJ;

    grp_nxt        = grp_r;
    idx_nxt        = idx_r;
    gap_pos_nxt    = gap_pos_r;
    prev_colon_nxt = prev_colon_r;
    gap_nxt        = gap_r;
    err_nxt        = err_r;

    if (!err_r) begin
      if (is_dec || is_alpha) begin
        prev_colon_nxt = 1'b0;
        grp_nxt[idx_r] = {grp_r[idx_r][ip6p_pkg::GROUP_W-ip6p_pkg::DIGIT_W-1:0], digit};
      end else if (prev_colon_r && gap_r) begin
        err_nxt = 1'b1;
      end else begin
        if (prev_colon_r) begin
          gap_nxt     = 1'b1;
          gap_pos_nxt = idx_r;
        end
        prev_colon_nxt = 1'b1;
        if (lc != ip6p_pkg::CH_COLON || idx_r == ip6p_pkg::IDX_MAX) begin
          err_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
    end
  end

  // address assembly: groups before the gap stay, groups after it move up
  always_comb begin
    head = '0;
    tail = '0;
    for (int j = 0; j < ip6p_pkg::GROUPS; j++) begin
      if (ip6p_pkg::IDX_W'(j) < gap_pos_nxt) begin
        head[j*ip6p_pkg::GROUP_W +: ip6p_pkg::GROUP_W] = grp_nxt[j];
      end
      if (ip6p_pkg::IDX_W'(j) > gap_pos_nxt) begin
        tail[j*ip6p_pkg::GROUP_W +: ip6p_pkg::GROUP_W] = grp_nxt[j];
      end
    end
    shift_amt = ip6p_pkg::IDX_MAX - idx_nxt;
    if (gap_nxt) begin
      words = head | (tail << (shift_amt * ip6p_pkg::GROUP_W));
    end else begin
      words = grp_nxt;
    end

    // group 0 goes to the most significant end
    addr = '0;
    for (int j = 0; j < ip6p_pkg::GROUPS; j++) begin
      addr[ip6p_pkg::ADDR_W-1-j*ip6p_pkg::GROUP_W -: ip6p_pkg::GROUP_W] =
        words[j*ip6p_pkg::GROUP_W +: ip6p_pkg::GROUP_W];
    end

    if (err_nxt) begin
      out_data_nxt   = '0;
      out_status_nxt = ip6p_pkg::STATUS_ERR;
    end else begin
      out_data_nxt   = {addr[ip6p_pkg::HALF_W-1:0], addr[ip6p_pkg::ADDR_W-1:ip6p_pkg::HALF_W]};
      out_status_nxt = ip6p_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r        <= '0;
      idx_r        <= '0;
      gap_pos_r    <= '0;
      prev_colon_r <= 1'b0;
      gap_r        <= 1'b0;
      err_r        <= 1'b0;
    end else if (accept) begin
      if (in_tlast) begin
        grp_r        <= '0;
        idx_r        <= '0;
        gap_pos_r    <= '0;
        prev_colon_r <= 1'b0;
        gap_r        <= 1'b0;
        err_r        <= 1'b0;
      end else begin
        grp_r        <= grp_nxt;
        idx_r        <= idx_nxt;
        gap_pos_r    <= gap_pos_nxt;
        prev_colon_r <= prev_colon_nxt;
        gap_r        <= gap_nxt;
        err_r        <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && in_tlast) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_tlast) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

// ===== rtl/ip6p_checker.sv =====
// ip6p_checker: port-level checks for the ipv6 text address parser
// depends on ip6p_pkg; bound to ipv6_text_address_parser_top below

module ip6p_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [7:0]   in_tdata,
  input logic         in_tlast,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [127:0] out_tdata,
  input logic [0:0]   out_tuser
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // an error result carries a zero address
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] == ip6p_pkg::STATUS_ERR |-> out_tdata == '0)
    else $error("error result with non-zero address");

  // the last character of an address always produces a result next cycle
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> out_tvalid)
    else $error("no result after last character");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // a middle character never invents a result
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !(in_tvalid && in_tready && in_tlast) |=> !out_tvalid)
    else $error("result without last character");

endmodule

bind ipv6_text_address_parser_top ip6p_checker u_ip6p_checker (.*);

// ===== test/ipv6_address_checker.sv =====
// ipv6_address_checker: watches both channels of the parser, works out the address
// each text should give and compares it with the items that come out
// depends on ip6p_pkg

module ipv6_address_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] char_in
  input  logic         in_tlast,   // last_char
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,  // [63:0] addr_high, [127:64] addr_low
  input  logic [0:0]   out_tuser,  // [0] parse_status
  output int           mismatches,
  output int           addr_pending
);

  typedef struct packed {
    logic [ip6p_pkg::HALF_W-1:0] hi;
    logic [ip6p_pkg::HALF_W-1:0] lo;
    logic                        status;
  } addr_word_t;

  // shadow of the parser state for the text in progress
  logic [ip6p_pkg::GROUP_W-1:0] grp [ip6p_pkg::GROUPS];
  logic [3:0]                   grp_idx;
  logic                         prev_colon;
  logic                         gap_seen;
  logic [2:0]                   gap_pos;
  logic                         bad_text;

  addr_word_t addr_due [$];
  int         fails = 0;

  assign mismatches = fails;

  task automatic clear_text();
    for (int i = 0; i < ip6p_pkg::GROUPS; i++) grp[i] = '0;
    grp_idx    = '0;
    prev_colon = 1'b0;
    gap_seen   = 1'b0;
    gap_pos    = '0;
    bad_text   = 1'b0;
  endtask

  task automatic take_char(input logic [7:0] ch);
    logic [7:0] c;
    logic [4:0] nxt;
    logic [3:0] dig;
    logic       is_digit;
    c        = ch;
    is_digit = 1'b1;
    dig      = '0;
    nxt      = grp_idx + 5'd1;
    if (c >= ip6p_pkg::CH_UP_A && c <= ip6p_pkg::CH_UP_Z) c = c + ip6p_pkg::CASE_OFFSET;
    if (c >= ip6p_pkg::CH_0 && c <= ip6p_pkg::CH_9) begin
      dig = 4'(c - ip6p_pkg::CH_0);
    end else if (c >= ip6p_pkg::CH_LO_A && c <= ip6p_pkg::CH_LO_F) begin
      dig = 4'(c - ip6p_pkg::CH_LO_A + 8'd10);
    end else begin
      is_digit = 1'b0;
    end
    if (is_digit) begin
      prev_colon = 1'b0;
      grp[grp_idx[2:0]] =
        {grp[grp_idx[2:0]][ip6p_pkg::GROUP_W-ip6p_pkg::DIGIT_W-1:0], dig};
    end else if (prev_colon && gap_seen) begin
      bad_text = 1'b1;
    end else begin
      // any separator right after another one marks the gap, bad or not
      if (prev_colon) begin
        gap_seen = 1'b1;
        gap_pos  = grp_idx[2:0];
      end
      prev_colon = 1'b1;
      if (c != ip6p_pkg::CH_COLON || nxt >= ip6p_pkg::GROUPS) bad_text = 1'b1;
      else grp_idx = nxt[3:0];
    end
  endtask

  function automatic addr_word_t build_addr();
    logic [ip6p_pkg::GROUP_W-1:0] w [ip6p_pkg::GROUPS];
    logic [2:0]                   top;
    addr_word_t                   r;
    r   = '0;
    top = grp_idx[2:0];
    for (int i = 0; i < ip6p_pkg::GROUPS; i++) w[i] = '0;
    if (bad_text) begin
      r.status = ip6p_pkg::STATUS_ERR;
    end else begin
      r.status = ip6p_pkg::STATUS_OK;
      if (gap_seen) begin
        for (int i = 0; i < gap_pos; i++) w[i] = grp[i];
        // groups after the gap are pushed to the right end
        for (int k = gap_pos + 1; k <= top; k++) w[3'(k + 7 - top)] = grp[k];
      end else begin
        for (int i = 0; i < ip6p_pkg::GROUPS; i++) w[i] = grp[i];
      end
      for (int i = 0; i < ip6p_pkg::GROUPS / 2; i++) begin
        r.hi = {r.hi[ip6p_pkg::HALF_W-ip6p_pkg::GROUP_W-1:0], w[i]};
        r.lo = {r.lo[ip6p_pkg::HALF_W-ip6p_pkg::GROUP_W-1:0], w[i + ip6p_pkg::GROUPS / 2]};
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [ip6p_pkg::HALF_W-1:0] want,
                             input logic [ip6p_pkg::HALF_W-1:0] got);
    if (got !== want) begin
      fails++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    addr_word_t got;
    addr_word_t want;
    if (!rst_n) begin
      clear_text();
      addr_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.hi     = out_tdata[ip6p_pkg::HALF_W-1:0];
        got.lo     = out_tdata[ip6p_pkg::ADDR_W-1:ip6p_pkg::HALF_W];
        got.status = out_tuser[0];
        if (addr_due.size() == 0) begin
          fails++;
          $display("%0t: unexpected address item, expected none, got %h %h status %b",
                   $time, got.hi, got.lo, got.status);
        end else begin
          want = addr_due.pop_front();
          check_field("addr_high", want.hi, got.hi);
          check_field("addr_low", want.lo, got.lo);
          check_field("parse_status", ip6p_pkg::HALF_W'(want.status),
                      ip6p_pkg::HALF_W'(got.status));
        end
      end
      if (in_tvalid && in_tready) begin
        // after an error the rest of the text is ignored
        if (!bad_text) take_char(in_tdata);
        if (in_tlast) begin
          addr_due.push_back(build_addr());
          clear_text();
        end
      end
    end
    addr_pending = addr_due.size();
  end

endmodule

// ===== test/tb.sv =====
// tb: drives address texts into ipv6_text_address_parser_top with random gaps and
// stalls; ipv6_address_checker does the prediction and comparison
// depends on ip6p_pkg, ipv6_text_address_parser_top and ipv6_address_checker

module tb;

  localparam int CYCLE_LIMIT = 400000;

  logic         clk        = 1'b0;
  logic         rst_n      = 1'b0;
  logic         in_tvalid  = 1'b0;
  logic         in_tready;
  logic [7:0]   in_tdata   = '0;   // [7:0] char_in
  logic         in_tlast   = 1'b0; // last_char
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;         // [63:0] addr_high, [127:64] addr_low
  logic [0:0]   out_tuser;         // [0] parse_status

  int fails;
  int addr_pending;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_len    = 0;
  int chars_sent  = 0;
  int cycle_count = 0;

  logic [7:0] text_buf [$];
  string      hex_chars = "0123456789abcdefABCDEF";

  ipv6_text_address_parser_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  ipv6_address_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (fails),
    .addr_pending(addr_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random stalls, or one long hold-off when asked for
  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        hold     = hold_len;
        hold_len = 0;
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_char(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
  endtask

  task automatic add_group();
    int n;
    // now and then more than four digits, so the group wraps
    n = ($urandom_range(9) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
    repeat (n) text_buf.push_back(hex_chars[$urandom_range(21)]);
  endtask

  task automatic add_groups(input int n);
    for (int i = 0; i < n; i++) begin
      if (i > 0) text_buf.push_back(ip6p_pkg::CH_COLON);
      add_group();
    end
  endtask

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    logic [7:0] lc;
    do begin
      c  = 8'($urandom_range(255));
      lc = (c >= ip6p_pkg::CH_UP_A && c <= ip6p_pkg::CH_UP_Z) ?
           c + ip6p_pkg::CASE_OFFSET : c;
    end while ((lc >= ip6p_pkg::CH_0 && lc <= ip6p_pkg::CH_9) ||
               (lc >= ip6p_pkg::CH_LO_A && lc <= ip6p_pkg::CH_LO_F) ||
               lc == ip6p_pkg::CH_COLON);
    return c;
  endfunction

  task automatic make_text();
    int kind;
    int left;
    int right;
    int n;
    kind  = $urandom_range(99);
    left  = $urandom_range(0, 6);
    right = $urandom_range(0, 6 - left);
    if (kind < 35) begin
      add_groups(left);
      add_str("::");
      add_groups(right);
    end else if (kind < 55) begin
      add_groups(ip6p_pkg::GROUPS);
    end else if (kind < 70) begin
      // loose forms: empty groups, stray leading or trailing colons
      n = $urandom_range(1, ip6p_pkg::GROUPS);
      for (int i = 0; i < n; i++) begin
        if (i > 0) text_buf.push_back(ip6p_pkg::CH_COLON);
        if ($urandom_range(2) != 0) add_group();
      end
    end else if (kind < 90) begin
      case ($urandom_range(3))
        0: begin
          add_groups($urandom_range(1, ip6p_pkg::GROUPS));
          text_buf.insert($urandom_range(0, text_buf.size()), bad_char());
        end
        1: add_groups($urandom_range(ip6p_pkg::GROUPS + 1, ip6p_pkg::GROUPS + 2));
        2: begin
          add_groups(left);
          add_str("::");
          add_groups(right);
          add_str("::");
          add_groups($urandom_range(0, 2));
        end
        default: begin
          add_groups(left);
          add_str(":::");
          add_groups(right);
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(255)));
    end
    if (text_buf.size() == 0) text_buf.push_back(ip6p_pkg::CH_COLON);
  endtask

  initial begin
    string directed [];
    int    phase_start;
    directed = '{"F", "::", ":::", "g", "1234a", ":", "1:", "ffff::"};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      add_str(directed[i]);
      send_text();
    end
    text_buf.push_back(8'h00);
    send_text();
    text_buf.push_back(8'hff);
    send_text();

    // long hold on the output while short texts keep coming, so the input backs up
    hold_len = 60;
    repeat (12) begin
      add_group();
      send_text();
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 26; stall_pct = 26; end
      endcase
      phase_start = chars_sent;
      while (chars_sent - phase_start < 80) begin
        make_text();
        send_text();
      end
    end
    in_tvalid <= 1'b0;

    do @(negedge clk); while (addr_pending != 0);
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
